/* src/sw2dmax_pkg.sv */
// Shared types and constants for the two-dimensional sliding-window maximum block.
package sw2dmax_pkg;

  // Sequencer states of the window engine.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COL,
    ST_ROW,
    ST_EMIT
  } seq_state_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1,
    REG_WIN_ROWS = 2'd2,
    REG_WIN_COLS = 2'd3
  } cfg_reg_t;

  localparam int NUM_ROWS_W = 13;
  localparam int NUM_COLS_W = 11;
  localparam int WIN_W      = 5;
  localparam int CFG_DATA_W = 13;
  localparam int SAMPLE_W   = 32;
  localparam int ROW_POS_W  = 12;
  localparam int ROW_LIMIT  = 4096;

endpackage

/* src/sliding_window_2d_max_core.sv */
// Streaming two-dimensional sliding-window maximum over a raster of signed samples.
//
// Input words arrive on s_tvalid/s_tready/s_tdata, one signed 32-bit sample per word,
// in row-major order. Result words leave on m_tvalid/m_tready/m_tdata with the window
// maximum in m_tdata; m_tuser carries the end-of-output-row mark and m_tlast the
// end-of-frame mark. The user must write geometry (rows, columns, window height and
// width) on cfg_valid/cfg_ready/cfg_index/cfg_data while idle; the block never checks.
//
// Each sample is written into a line memory holding the last MAX_WIN_ROWS rows. The
// column maximum is then formed by reading win_rows-1 older rows of that column, one
// line-memory read per cycle, and stored in a small ring of column maxima. The window
// maximum reads win_cols-1 entries of that ring, one per cycle. A word whose row has no
// window yet is only written to the line memory; otherwise the column stage runs, and
// where a window ends the row stage follows, after which the output register is loaded.
// A finished result waits in the output register while the next word is taken; only
// when a second result is ready and the receiver still stalls does the engine wait.
// Reset clears the position counters and sets every configuration register to 1; no word
// is taken while it is held, and the memory contents need no clearing.
module sliding_window_2d_max_core #(
  parameter int MAX_COLS     = 1024,
  parameter int MAX_WIN_ROWS = 16,
  parameter int MAX_WIN_COLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] window_max
  output logic        m_tlast,   // frame_end
  output logic [0:0]  m_tuser,   // [0] row_end
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [sw2dmax_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NCW  = $clog2(MAX_COLS + 1);
  localparam int RRW  = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
  localparam int RCW  = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
  localparam int MAXW = (MAX_WIN_ROWS > MAX_WIN_COLS) ? MAX_WIN_ROWS : MAX_WIN_COLS;
  localparam int KW   = $clog2(MAXW + 1);
  localparam int RW   = sw2dmax_pkg::ROW_POS_W;
  localparam int NRW  = sw2dmax_pkg::NUM_ROWS_W;
  localparam int SW   = sw2dmax_pkg::SAMPLE_W;

  // Configuration registers.
  logic [sw2dmax_pkg::NUM_ROWS_W-1:0] num_rows;
  logic [sw2dmax_pkg::NUM_COLS_W-1:0] num_cols;
  logic [sw2dmax_pkg::WIN_W-1:0]      win_rows;
  logic [sw2dmax_pkg::WIN_W-1:0]      win_cols;

  // Effective geometry after clamping.
  logic [NRW-1:0] nr_eff;
  logic [NCW-1:0] nc_eff;
  logic [KW-1:0]  wr_eff;
  logic [KW-1:0]  wc_eff;

  // Position state.
  logic [CW-1:0]  col_pos;
  logic [RW-1:0]  row_pos;
  logic [RRW-1:0] ring_row;
  logic [RCW-1:0] ring_col;

  // Current item.
  sw2dmax_pkg::seq_state_t state, state_next;
  logic [CW-1:0]   it_c;
  logic [RCW-1:0]  it_ring_col;
  logic            it_last_col;
  logic            it_last_row;
  logic            it_emit;
  logic [KW-1:0]   k;
  logic [RRW-1:0]  rd_row;
  logic [RCW-1:0]  rd_col;
  logic            rd_pend;
  logic [SW-1:0]   acc;

  // Memories and their registered read data.
  logic [SW-1:0] line_mem [MAX_WIN_ROWS][MAX_COLS];
  logic [SW-1:0] colmax_mem [MAX_WIN_COLS];
  logic [SW-1:0] ln_q;
  logic [SW-1:0] cm_q;

  // Decoded conditions and strobes.
  logic accept;
  logic last_col;
  logic last_row;
  logic do_col;
  logic do_row;
  logic col_issue;
  logic row_issue;
  logic cm_wr;
  logic out_load;
  logic [SW-1:0] rd_data;

  assign cfg_ready = !rst;

  always_comb begin
    if (num_rows == '0) begin
      nr_eff = NRW'(1);
    end else if (32'(num_rows) > sw2dmax_pkg::ROW_LIMIT) begin
      nr_eff = NRW'(sw2dmax_pkg::ROW_LIMIT);
    end else begin
      nr_eff = num_rows;
    end
    if (num_cols == '0) begin
      nc_eff = NCW'(1);
    end else if (32'(num_cols) > MAX_COLS) begin
      nc_eff = NCW'(MAX_COLS);
    end else begin
      nc_eff = NCW'(num_cols);
    end
    if (win_rows == '0) begin
      wr_eff = KW'(1);
    end else if (32'(win_rows) > MAX_WIN_ROWS) begin
      wr_eff = KW'(MAX_WIN_ROWS);
    end else begin
      wr_eff = KW'(win_rows);
    end
    if (win_cols == '0) begin
      wc_eff = KW'(1);
    end else if (32'(win_cols) > MAX_WIN_COLS) begin
      wc_eff = KW'(MAX_WIN_COLS);
    end else begin
      wc_eff = KW'(win_cols);
    end
  end

  assign last_col = (32'(col_pos) + 32'd1) >= 32'(nc_eff);
  assign last_row = (32'(row_pos) + 32'd1) >= 32'(nr_eff);
  assign do_col   = (32'(row_pos) + 32'd1) >= 32'(wr_eff);
  assign do_row   = (32'(col_pos) + 32'd1) >= 32'(wc_eff);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      sw2dmax_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = do_col ? sw2dmax_pkg::ST_COL : sw2dmax_pkg::ST_IDLE;
        end
      end
      sw2dmax_pkg::ST_COL: begin
        if (k >= wr_eff && !rd_pend) begin
          state_next = it_emit ? sw2dmax_pkg::ST_ROW : sw2dmax_pkg::ST_IDLE;
        end
      end
      sw2dmax_pkg::ST_ROW: begin
        if (k >= wc_eff && !rd_pend) begin
          state_next = sw2dmax_pkg::ST_EMIT;
        end
      end
      sw2dmax_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = sw2dmax_pkg::ST_IDLE;
        end
      end
      default: state_next = sw2dmax_pkg::ST_IDLE;
    endcase
  end

  // Strobes decoded from the state.
  always_comb begin
    s_tready  = 1'b0;
    col_issue = 1'b0;
    row_issue = 1'b0;
    cm_wr     = 1'b0;
    out_load  = 1'b0;
    case (state)
      sw2dmax_pkg::ST_IDLE: s_tready = !rst;
      sw2dmax_pkg::ST_COL: begin
        col_issue = (k < wr_eff);
        cm_wr     = (k >= wr_eff) && !rd_pend;
      end
      sw2dmax_pkg::ST_ROW:  row_issue = (k < wc_eff);
      sw2dmax_pkg::ST_EMIT: out_load = !m_tvalid || m_tready;
      default: s_tready = 1'b0;
    endcase
  end

  assign accept  = s_tvalid && s_tready;
  assign rd_data = (state == sw2dmax_pkg::ST_ROW) ? cm_q : ln_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= sw2dmax_pkg::NUM_ROWS_W'(1);
      num_cols <= sw2dmax_pkg::NUM_COLS_W'(1);
      win_rows <= sw2dmax_pkg::WIN_W'(1);
      win_cols <= sw2dmax_pkg::WIN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sw2dmax_pkg::REG_NUM_ROWS: num_rows <= cfg_data[sw2dmax_pkg::NUM_ROWS_W-1:0];
        sw2dmax_pkg::REG_NUM_COLS: num_cols <= cfg_data[sw2dmax_pkg::NUM_COLS_W-1:0];
        sw2dmax_pkg::REG_WIN_ROWS: win_rows <= cfg_data[sw2dmax_pkg::WIN_W-1:0];
        sw2dmax_pkg::REG_WIN_COLS: win_cols <= cfg_data[sw2dmax_pkg::WIN_W-1:0];
        default: num_rows <= num_rows;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sw2dmax_pkg::ST_IDLE;
      col_pos  <= '0;
      row_pos  <= '0;
      ring_row <= '0;
      ring_col <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= col_issue || row_issue;
      if (accept) begin
        if (last_col) begin
          col_pos  <= '0;
          ring_col <= '0;
          if (last_row) begin
            row_pos  <= '0;
            ring_row <= '0;
          end else begin
            row_pos  <= row_pos + RW'(1);
            ring_row <= (ring_row == RRW'(MAX_WIN_ROWS - 1)) ? '0 : ring_row + RRW'(1);
          end
        end else begin
          col_pos  <= col_pos + CW'(1);
          ring_col <= (ring_col == RCW'(MAX_WIN_COLS - 1)) ? '0 : ring_col + RCW'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item registers and accumulator.
  always_ff @(posedge clk) begin
    if (accept) begin
      acc         <= s_tdata;
      it_c        <= col_pos;
      it_ring_col <= ring_col;
      it_last_col <= last_col;
      it_last_row <= last_row;
      it_emit     <= do_row;
      k           <= KW'(1);
      rd_row      <= (ring_row == '0) ? RRW'(MAX_WIN_ROWS - 1) : ring_row - RRW'(1);
    end else begin
      if (rd_pend && ($signed(rd_data) > $signed(acc))) begin
        acc <= rd_data;
      end
      if (col_issue) begin
        k      <= k + KW'(1);
        rd_row <= (rd_row == '0) ? RRW'(MAX_WIN_ROWS - 1) : rd_row - RRW'(1);
      end
      if (cm_wr) begin
        // The ring walk for the row stage starts one column to the left.
        k      <= KW'(1);
        rd_col <= (it_ring_col == '0) ? RCW'(MAX_WIN_COLS - 1) : it_ring_col - RCW'(1);
      end
      if (row_issue) begin
        k      <= k + KW'(1);
        rd_col <= (rd_col == '0) ? RCW'(MAX_WIN_COLS - 1) : rd_col - RCW'(1);
      end
    end
  end

  // Line memory: one write port for incoming samples, one registered read port.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[ring_row][col_pos] <= s_tdata;
    end
    if (col_issue) begin
      ln_q <= line_mem[rd_row][it_c];
    end
  end

  // Ring of column maxima.
  always_ff @(posedge clk) begin
    if (cm_wr) begin
      colmax_mem[it_ring_col] <= acc;
    end
    if (row_issue) begin
      cm_q <= colmax_mem[rd_col];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= acc;
      m_tuser[0] <= it_last_col;
      m_tlast    <= it_last_col && it_last_row;
    end
  end

endmodule
